[hdl/abf_pkg.sv]
// Shared types and constants for the allpass bandpass filter core.
// No dependencies; imported by the datapath and the top level.
package abf_pkg;

    localparam int CHANNEL_BITS   = 3;
    localparam int CFG_INDEX_BITS = 2;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COEF_C = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COEF_E = 2'd1;

    // pipeline control from the top level to the datapath
    typedef struct packed {
        logic load_s2;      // products of the read stage are captured
        logic load_out;     // finished sample moves to the output register
        logic s2_in_range;  // the item in the sum stage has a real channel
    } abf_ctrl_t;

endpackage

[hdl/abf_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module abf_ram #(
    parameter int WIDTH = 100,
    parameter int DEPTH = 8
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read-first: a read of the entry being written returns the old data
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/abf_datapath.sv]
// Multiply and sum stages of the allpass section, plus output saturation.
// Depends on abf_pkg for the pipeline control struct.
module abf_datapath #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  abf_pkg::abf_ctrl_t                  ctrl,
    input  logic signed [COEF_FRAC_BITS+1:0]    coef_c,
    input  logic signed [COEF_FRAC_BITS+1:0]    coef_e,
    input  logic signed [SAMPLE_BITS-1:0]       x,
    input  logic signed [SAMPLE_BITS-1:0]       x1,
    input  logic signed [SAMPLE_BITS-1:0]       x2,
    input  logic signed [SAMPLE_BITS+1:0]       y1,
    input  logic signed [SAMPLE_BITS+1:0]       y2,
    output logic signed [SAMPLE_BITS+1:0]       y_new,
    output logic signed [SAMPLE_BITS-1:0]       keep_x1,
    output logic signed [SAMPLE_BITS-1:0]       keep_x2,
    output logic signed [SAMPLE_BITS+1:0]       keep_y2,
    output logic signed [SAMPLE_BITS-1:0]       sample_out
);

    import abf_pkg::*;

    localparam int COEF_BITS  = COEF_FRAC_BITS + 2;
    localparam int STATE_BITS = SAMPLE_BITS + 2;
    localparam int PX_BITS    = COEF_BITS + SAMPLE_BITS;
    localparam int PY_BITS    = COEF_BITS + STATE_BITS;
    localparam int ACC_BITS   = PY_BITS + 3;
    localparam int DIFF_BITS  = STATE_BITS + 1;
    localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) << (COEF_FRAC_BITS - 1);

    logic signed [PX_BITS-1:0]    prod_cx;
    logic signed [PX_BITS-1:0]    prod_ex1;
    logic signed [PY_BITS-1:0]    prod_ey1;
    logic signed [PY_BITS-1:0]    prod_cy2;

    logic signed [PX_BITS-1:0]    p_cx_reg;
    logic signed [PX_BITS-1:0]    p_ex1_reg;
    logic signed [PY_BITS-1:0]    p_ey1_reg;
    logic signed [PY_BITS-1:0]    p_cy2_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] x1_reg;
    logic signed [SAMPLE_BITS-1:0] x2_reg;
    logic signed [STATE_BITS-1:0]  y1_reg;

    logic signed [ACC_BITS-1:0]   acc;
    logic signed [ACC_BITS-1:0]   acc_shift;
    logic [ACC_BITS-STATE_BITS:0] acc_hi;
    logic signed [DIFF_BITS-1:0]  diff;
    logic signed [DIFF_BITS-1:0]  half;
    logic [DIFF_BITS-SAMPLE_BITS:0] half_hi;
    logic signed [SAMPLE_BITS-1:0] sample_next;

    assign prod_cx  = PX_BITS'(coef_c) * PX_BITS'(x);
    assign prod_ex1 = PX_BITS'(coef_e) * PX_BITS'(x1);
    assign prod_ey1 = PY_BITS'(coef_e) * PY_BITS'(y1);
    assign prod_cy2 = PY_BITS'(coef_c) * PY_BITS'(y2);

    always_ff @(posedge aclk) begin
        if (ctrl.load_s2) begin
            p_cx_reg  <= prod_cx;
            p_ex1_reg <= prod_ex1;
            p_ey1_reg <= prod_ey1;
            p_cy2_reg <= prod_cy2;
            x_reg     <= x;
            x1_reg    <= x1;
            x2_reg    <= x2;
            y1_reg    <= y1;
        end
    end

    // y = -c*x + e*x1 + x2 - e*y1 + c*y2, round half up to the sample grid, clip to the state width
    always_comb begin
        acc = ACC_BITS'(p_ex1_reg) - ACC_BITS'(p_cx_reg)
            + (ACC_BITS'(x2_reg) <<< COEF_FRAC_BITS)
            - ACC_BITS'(p_ey1_reg) + ACC_BITS'(p_cy2_reg) + ROUND_HALF;
        acc_shift = acc >>> COEF_FRAC_BITS;
        acc_hi    = acc_shift[ACC_BITS-1:STATE_BITS-1];
        if ((&acc_hi) || !(|acc_hi)) begin
            y_new = acc_shift[STATE_BITS-1:0];
        end else begin
            y_new = {acc_hi[ACC_BITS-STATE_BITS], {(STATE_BITS-1){~acc_hi[ACC_BITS-STATE_BITS]}}};
        end
    end

    // bandpass = (x - y) / 2, floored, then clipped to the sample width
    always_comb begin
        diff    = DIFF_BITS'(x_reg) - DIFF_BITS'(y_new);
        half    = diff >>> 1;
        half_hi = half[DIFF_BITS-1:SAMPLE_BITS-1];
        if ((&half_hi) || !(|half_hi)) begin
            sample_next = half[SAMPLE_BITS-1:0];
        end else begin
            sample_next = {half_hi[DIFF_BITS-SAMPLE_BITS],
                           {(SAMPLE_BITS-1){~half_hi[DIFF_BITS-SAMPLE_BITS]}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_out) begin
            sample_out <= ctrl.s2_in_range ? sample_next : '0;
        end
    end

    assign keep_x1 = x_reg;
    assign keep_x2 = x1_reg;
    assign keep_y2 = y1_reg;

endmodule

[hdl/allpass_bandpass_filter_core.sv]
// Top level of the multichannel allpass bandpass filter core.
// Depends on abf_pkg, abf_ram and abf_datapath.
//
// Usage:
//   s_ channel: one beat per sample; s_tuser carries the channel number,
//   s_tdata the signed sample. m_ channel returns one beat per input beat,
//   in order, with the same channel on m_tuser and the bandpass sample on
//   m_tdata. cfg_ channel writes coef_c (index 0) and coef_e (index 1);
//   other indexes are ignored. Write coefficients only while idle.
//   Path: an accepted beat passes the read stage, the sum stage and the output
//   register before it shows on m_. Throughput: one beat per cycle while m_tready
//   is high. Two consecutive beats on the same channel stall: the second waits
//   for the first one's new allpass output, since the state read/modify/write
//   loop through the channel RAM spans the multiply and sum stages.
//   Channel numbers at or above CHANNELS return zero and leave state alone.
//   Reset: all channel state reads as zero (per-channel valid flags are
//   cleared; no RAM sweep), coefficients return to zero.
//   Stall: with m_tready low the output register holds; the two internal
//   stages keep filling, so up to two more beats are taken before s_tready drops.
module allpass_bandpass_filter_core #(
    parameter int CHANNELS       = 8,
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,   // sample_in
    input  logic [abf_pkg::CHANNEL_BITS-1:0]    s_tuser,   // channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,   // sample_out
    output logic [abf_pkg::CHANNEL_BITS-1:0]    m_tuser,   // channel_out
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [abf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [COEF_FRAC_BITS+1:0]           cfg_data
);

    import abf_pkg::*;

    localparam int COEF_BITS   = COEF_FRAC_BITS + 2;
    localparam int STATE_BITS  = SAMPLE_BITS + 2;
    localparam int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int ADDR_BITS   = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
    localparam int ENTRY_BITS  = 2 * SAMPLE_BITS + 2 * STATE_BITS;

    logic signed [COEF_BITS-1:0]    coef_c_reg;
    logic signed [COEF_BITS-1:0]    coef_e_reg;

    logic                           s1_valid_reg;
    logic [CHANNEL_BITS-1:0]        s1_ch_reg;
    logic                           s1_in_range_reg;
    logic signed [SAMPLE_BITS-1:0]  s1_x_reg;

    logic                           s2_valid_reg;
    logic [CHANNEL_BITS-1:0]        s2_ch_reg;
    logic                           s2_in_range_reg;

    logic                           out_valid_reg;
    logic [CHANNEL_BITS-1:0]        out_ch_reg;

    logic                           wb_valid_reg;
    logic [ADDR_BITS-1:0]           wb_addr_reg;
    logic [ENTRY_BITS-1:0]          wb_data_reg;
    logic [CHANNELS-1:0]            entry_valid_reg;

    logic                           in_fire;
    logic                           in_range;
    logic [ADDR_BITS-1:0]           in_addr;
    logic [ADDR_BITS-1:0]           s1_addr;
    logic [ADDR_BITS-1:0]           s2_addr;
    logic                           hazard;
    logic                           out_free;
    logic                           s2_fire;
    logic                           s2_free;
    logic                           s2_load;
    logic                           s1_free;
    logic                           ram_we;
    logic [ENTRY_BITS-1:0]          ram_rdata;
    logic [ENTRY_BITS-1:0]          ram_wdata;
    logic [ENTRY_BITS-1:0]          entry;
    abf_ctrl_t                      ctrl;

    logic signed [SAMPLE_BITS-1:0]  st_x1;
    logic signed [SAMPLE_BITS-1:0]  st_x2;
    logic signed [STATE_BITS-1:0]   st_y1;
    logic signed [STATE_BITS-1:0]   st_y2;
    logic signed [STATE_BITS-1:0]   y_new;
    logic signed [SAMPLE_BITS-1:0]  keep_x1;
    logic signed [SAMPLE_BITS-1:0]  keep_x2;
    logic signed [STATE_BITS-1:0]   keep_y2;
    logic signed [SAMPLE_BITS-1:0]  sample_out;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_c_reg <= '0;
            coef_e_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_COEF_C: coef_c_reg <= cfg_data;
                CFG_COEF_E: coef_e_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    assign in_fire  = s_tvalid && s_tready;
    assign in_range = int'(s_tuser) < CHANNELS;
    assign in_addr  = ADDR_BITS'(s_tuser);
    assign s1_addr  = ADDR_BITS'(s1_ch_reg);
    assign s2_addr  = ADDR_BITS'(s2_ch_reg);

    // same channel one stage ahead: its new y is not written yet
    assign hazard   = s1_valid_reg && s2_valid_reg && s1_in_range_reg && s2_in_range_reg
                      && (s1_ch_reg == s2_ch_reg);
    assign out_free = !out_valid_reg || m_tready;
    assign s2_fire  = s2_valid_reg && out_free;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s2_load  = s1_valid_reg && !hazard && s2_free;
    assign s1_free  = !s1_valid_reg || s2_load;
    assign s_tready = s1_free;

    assign ctrl.load_s2     = s2_load;
    assign ctrl.load_out    = s2_fire;
    assign ctrl.s2_in_range = s2_in_range_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_free) begin
                s1_valid_reg <= in_fire;
            end
            if (s2_free) begin
                s2_valid_reg <= s2_load;
            end
            if (out_free) begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            s1_ch_reg       <= s_tuser;
            s1_in_range_reg <= in_range;
            s1_x_reg        <= s_tdata[SAMPLE_BITS-1:0];
        end
        if (s2_load) begin
            s2_ch_reg       <= s1_ch_reg;
            s2_in_range_reg <= s1_in_range_reg;
        end
        if (s2_fire) begin
            out_ch_reg <= s2_ch_reg;
        end
    end

    // ---------------- channel state store ----------------
    assign ram_we    = s2_fire && s2_in_range_reg;
    assign ram_wdata = {keep_y2, y_new, keep_x2, keep_x1};

    abf_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s2_addr),
        .wdata (ram_wdata),
        .re    (in_fire),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
            wb_valid_reg    <= 1'b0;
        end else if (ram_we) begin
            entry_valid_reg[s2_addr] <= 1'b1;
            wb_valid_reg             <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_we) begin
            wb_addr_reg <= s2_addr;
            wb_data_reg <= ram_wdata;
        end
    end

    // take the last write when it hit this channel, else the RAM, else zero
    always_comb begin
        priority if (wb_valid_reg && (wb_addr_reg == s1_addr)) begin
            entry = wb_data_reg;
        end else if (s1_in_range_reg && entry_valid_reg[s1_addr]) begin
            entry = ram_rdata;
        end else begin
            entry = '0;
        end
    end

    assign st_x1 = entry[SAMPLE_BITS-1:0];
    assign st_x2 = entry[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign st_y1 = entry[2*SAMPLE_BITS+STATE_BITS-1:2*SAMPLE_BITS];
    assign st_y2 = entry[ENTRY_BITS-1:2*SAMPLE_BITS+STATE_BITS];

    abf_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .coef_c     (coef_c_reg),
        .coef_e     (coef_e_reg),
        .x          (s1_x_reg),
        .x1         (st_x1),
        .x2         (st_x2),
        .y1         (st_y1),
        .y2         (st_y2),
        .y_new      (y_new),
        .keep_x1    (keep_x1),
        .keep_x2    (keep_x2),
        .keep_y2    (keep_y2),
        .sample_out (sample_out)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ch_reg;
    assign m_tdata  = TDATA_BITS'($unsigned(sample_out));

endmodule

[test/testbench.sv]
// Self-checking bench for allpass_bandpass_filter_core: a per-channel allpass
// predictor runs alongside the core and every m_ beat is compared with it.
// Depends on abf_pkg and the core RTL only.
`timescale 1ns / 100ps

module testbench;
    import abf_pkg::*;

    localparam int  CHANNELS    = 8;
    localparam int  SAMPLE_BITS = 24;
    localparam int  COEF_FRAC   = 16;
    localparam int  CYCLE_LIMIT = 150000;
    localparam int  DRAIN_PAUSE = 8;
    localparam int  PRINT_LIMIT = 40;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'sh7fffff;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'sh800000;
    localparam logic signed [COEF_FRAC+1:0]   COEF_MAX   = 18'sh1ffff;
    localparam logic signed [COEF_FRAC+1:0]   COEF_MIN   = 18'sh20000;

    // indexes with no register behind them
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNMAPPED_A = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNMAPPED_B = 2'd3;

    typedef struct {
        logic [CHANNEL_BITS-1:0] channel;
        logic [SAMPLE_BITS-1:0]  sample;
    } bandpass_beat_t;

    logic                         aclk      = 1'b0;
    logic                         aresetn   = 1'b0;
    logic                         s_tvalid  = 1'b0;
    logic                         s_tready;
    logic [SAMPLE_BITS-1:0]       s_tdata   = '0;
    logic [CHANNEL_BITS-1:0]      s_tuser   = '0;
    logic                         m_tvalid;
    logic                         m_tready  = 1'b0;
    logic [SAMPLE_BITS-1:0]       m_tdata;
    logic [CHANNEL_BITS-1:0]      m_tuser;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [CFG_INDEX_BITS-1:0]    cfg_index = '0;
    logic [COEF_FRAC+1:0]         cfg_data  = '0;

    // predictor state
    logic signed [COEF_FRAC+1:0]   coef_c;
    logic signed [COEF_FRAC+1:0]   coef_e;
    logic signed [SAMPLE_BITS-1:0] past_in_1 [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] past_in_2 [CHANNELS];
    logic signed [SAMPLE_BITS+1:0] past_ap_1 [CHANNELS];
    logic signed [SAMPLE_BITS+1:0] past_ap_2 [CHANNELS];

    bandpass_beat_t pending_outputs [$];
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;
    int             mismatches    = 0;
    int             beats_seen    = 0;
    int             cycle_count   = 0;

    allpass_bandpass_filter_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("allpass_bandpass_filter_core test failed");
            $finish;
        end
    end

    task report_mismatch(input string what, input longint got, input longint want);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch at beat %0d, %s: got %0d, expected %0d",
                     beats_seen, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin : check_outputs
        bandpass_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_outputs.size() == 0) begin
                report_mismatch("beat with nothing expected", longint'(m_tuser),
                                longint'(-1));
            end else begin
                want = pending_outputs.pop_front();
                if (m_tuser !== want.channel)
                    report_mismatch("channel", longint'(m_tuser), longint'(want.channel));
                if (m_tdata !== want.sample)
                    report_mismatch("sample", longint'($signed(m_tdata)),
                                    longint'($signed(want.sample)));
            end
            beats_seen++;
        end
    end

    function automatic longint saturate(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : (v < lo) ? lo : v;
    endfunction

    // Run one sample through the channel's allpass section and queue the
    // bandpass output it must produce.
    task predict_bandpass(input logic [CHANNEL_BITS-1:0] ch,
                          input logic signed [SAMPLE_BITS-1:0] x);
        longint         acc;
        longint         y;
        longint         z;
        bandpass_beat_t beat;
        beat.channel = ch;
        if (int'(ch) >= CHANNELS) begin
            beat.sample = '0;
        end else begin
            acc = -(longint'(coef_c) * longint'(x))
                + longint'(coef_e) * longint'(past_in_1[ch])
                + (longint'(past_in_2[ch]) <<< COEF_FRAC)
                - longint'(coef_e) * longint'(past_ap_1[ch])
                + longint'(coef_c) * longint'(past_ap_2[ch])
                + (longint'(1) <<< (COEF_FRAC - 1));
            y = saturate(acc >>> COEF_FRAC, SAMPLE_BITS + 2);
            past_ap_2[ch] = past_ap_1[ch];
            past_ap_1[ch] = y[SAMPLE_BITS+1:0];
            past_in_2[ch] = past_in_1[ch];
            past_in_1[ch] = x;
            z = saturate((longint'(x) - y) >>> 1, SAMPLE_BITS);
            beat.sample = z[SAMPLE_BITS-1:0];
        end
        pending_outputs.push_back(beat);
    endtask

    task send_sample(input logic [CHANNEL_BITS-1:0] ch,
                     input logic signed [SAMPLE_BITS-1:0] x);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ch;
        s_tdata  <= x;
        do @(posedge aclk); while (!s_tready);
        predict_bandpass(ch, x);
    endtask

    // Drop valid and hold off until every queued result has come back.
    task drain_outputs();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge aclk);
    endtask

    task write_register(input logic [CFG_INDEX_BITS-1:0] index,
                        input logic [COEF_FRAC+1:0] value);
        drain_outputs();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (index == CFG_COEF_C)
            coef_c = value;
        else if (index == CFG_COEF_E)
            coef_e = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [SAMPLE_BITS-1:0] draw_sample();
        case ($urandom_range(7))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return SAMPLE_BITS'($urandom_range(511)) - SAMPLE_BITS'(256);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task apply_reset();
        coef_c = '0;
        coef_e = '0;
        for (int k = 0; k < CHANNELS; k++) begin
            past_in_1[k] = '0;
            past_in_2[k] = '0;
            past_ap_1[k] = '0;
            past_ap_2[k] = '0;
        end
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
    endtask

    // Zero coefficients reduce the section to a two-sample delay, so fresh
    // state shows up directly; channel 0 gets enough beats to see x2 return.
    task test_cleared_state();
        send_idle_pct = 20;
        recv_idle_pct = 30;
        send_sample(3'd0, SAMPLE_MAX);
        send_sample(3'd7, SAMPLE_MIN);
        send_sample(3'd1, '0);
        send_sample(3'd2, -24'sd1);
        send_sample(3'd3, 24'sd1);
        send_sample(3'd4, draw_sample());
        send_sample(3'd5, draw_sample());
        send_sample(3'd6, draw_sample());
        send_sample(3'd0, SAMPLE_MIN);
        send_sample(3'd0, 24'sd1);
        send_sample(3'd0, SAMPLE_MAX);
    endtask

    task test_register_writes();
        write_register(CFG_UNMAPPED_A, '1);
        write_register(CFG_UNMAPPED_B, '1);
        send_sample(3'd5, SAMPLE_MAX);
        send_sample(3'd5, SAMPLE_MIN);
        write_register(CFG_COEF_C, COEF_MAX);
        write_register(CFG_COEF_E, COEF_MAX);
        send_sample(3'd1, SAMPLE_MAX);
        send_sample(3'd1, SAMPLE_MIN);
        send_sample(3'd1, SAMPLE_MAX);
    endtask

    // Coefficients of -2 make the feedback run away: allpass state and the
    // output both clip, and the other channel must stay untouched.
    task test_saturation();
        write_register(CFG_COEF_C, COEF_MIN);
        write_register(CFG_COEF_E, COEF_MIN);
        repeat (4) send_sample(3'd3, SAMPLE_MAX);
        send_sample(3'd6, SAMPLE_MIN);
        repeat (3) send_sample(3'd3, SAMPLE_MIN);
    endtask

    task test_random_stream(input int send_pct, input int recv_pct,
                            input int c_first, input int e_first,
                            input int c_second, input int e_second,
                            input int n_items);
        logic [CHANNEL_BITS-1:0] ch;
        ch = '0;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_register(CFG_COEF_C, c_first[COEF_FRAC+1:0]);
        write_register(CFG_COEF_E, e_first[COEF_FRAC+1:0]);
        for (int i = 0; i < n_items; i++) begin
            if (i == n_items / 4)
                drain_outputs();
            if (i == n_items / 2) begin
                write_register(CFG_COEF_C, c_second[COEF_FRAC+1:0]);
                write_register(CFG_COEF_E, e_second[COEF_FRAC+1:0]);
                write_register($urandom_range(1) ? CFG_UNMAPPED_A : CFG_UNMAPPED_B,
                               (COEF_FRAC+2)'($urandom));
            end
            // repeat the channel often to hit the back-to-back stall
            if ($urandom_range(99) >= 30)
                ch = CHANNEL_BITS'($urandom_range(CHANNELS - 1));
            send_sample(ch, draw_sample());
        end
        drain_outputs();
    endtask

    function automatic int moderate_coef();
        return int'($urandom_range(131070)) - 65535;
    endfunction

    function automatic int any_coef();
        return int'($urandom_range(262143)) - 131072;
    endfunction

    initial begin
        apply_reset();
        test_cleared_state();
        test_register_writes();
        test_saturation();
        test_random_stream(38, 64, int'(COEF_MAX), int'(COEF_MAX),
                           moderate_coef(), moderate_coef(), 367);
        test_random_stream(64, 38, int'(COEF_MIN), int'(COEF_MIN),
                           any_coef(), any_coef(), 367);
        test_random_stream(0, 0, moderate_coef(), moderate_coef(),
                           int'(COEF_MIN), int'(COEF_MAX), 367);
        drain_outputs();
        repeat (DRAIN_PAUSE) @(posedge aclk);
        if (mismatches == 0) begin
            $display("allpass_bandpass_filter_core test passed");
        end else begin
            $display("allpass_bandpass_filter_core test failed");
        end
        $finish;
    end

endmodule
